### src/websocket_frame_deframer_core_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clock, off during reset.
`define WSFD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, checked on clock, off during reset.
`define WSFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

### src/wsfd_pkg.sv
// Types and constants of the websocket frame deframer.
package wsfd_pkg;

   localparam int LENGTH_BITS = 64;
   localparam int CMP_BITS    = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

   localparam logic [31:0] MAX_LEN_RESET = 32'(10 * 1024 * 1024);

   localparam logic [7:0] FIN_MASK    = 8'h80;
   localparam logic [7:0] MASKED_FLAG = 8'h80;
   localparam logic [7:0] OPCODE_MASK = 8'h0F;
   localparam logic [7:0] LEN_MASK    = 8'h7F;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // header_byte_count value on the last byte of each header section
   localparam logic [2:0] EXT16_LAST = 3'd1;
   localparam logic [2:0] EXT64_LAST = 3'd7;
   localparam logic [2:0] MASK_LAST  = 3'd3;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXT16,
      PH_EXT64,
      PH_MASK,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [3:0]  opcode;
      logic        fin;
      logic        last;
   } beat_type;

endpackage

### src/websocket_frame_deframer_core.sv
// Byte-serial RFC 6455 frame deframer with a two-deep result buffer.
//
//   channel   dir   ports              contents
//   req       in    req_t*             one received byte per beat
//   rsp       out   rsp_t*             unmasked payload byte, empty-frame or error beat
//   csr       in    csr_we/csr_wdata   max_payload_length, written any cycle
//
// One byte per clock while req_tready is high: a beat is decoded in the cycle it is
// accepted and its result is registered in the output register or the skid slot.
// Reset is synchronous: parser back to "awaiting first header byte", output
// buffer empty, max_payload_length back to 10 MiB.
// A stalled rsp side is absorbed by a skid register; req_tready drops only when
// both result slots are full. After an oversize error bytes are accepted but dropped.
`include "websocket_frame_deframer_core_assert.svh"

module websocket_frame_deframer_core
   import wsfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                    // [12] final_fragment, [15:13] zero
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast,   // frame_end
   // configuration
   input  logic        csr_we,
   input  logic [31:0] csr_wdata    // max_payload_length
);

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   phase_type              phase_ff,  phase_in;
   logic [31:0]            max_len_ff;
   logic [3:0]             opcode_ff, opcode_in;
   logic                   fin_ff,    fin_in;
   logic                   masked_ff, masked_in;
   logic [LENGTH_BITS-1:0] len_ff,    len_in;
   logic                   wide_ff,   wide_in;   // length bits shifted past LENGTH_BITS
   logic [LENGTH_BITS-1:0] rem_ff,    rem_in;
   logic [2:0]             cnt_ff,    cnt_in;
   logic [31:0]            key_ff,    key_in;
   logic [1:0]             midx_ff,   midx_in;

   // output register plus skid slot
   beat_type               out_ff,    out_in;
   logic                   out_vld_ff, out_vld_in;
   beat_type               skid_ff,   skid_in;
   logic                   skid_vld_ff, skid_vld_in;

   logic                   accept;
   logic [7:0]             rx;
   logic [6:0]             len_code;
   logic                   sect_last;     // last byte of ext-length or mask section
   logic                   hdr_done;      // header complete on this beat
   logic                   oversize;
   logic                   len_zero;
   logic                   pay_last;
   logic [7:0]             key_byte;
   beat_type               res;
   logic                   res_vld;
   logic                   out_take;

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign len_code   = 7'(rx & LEN_MASK);

   // ---------------------------------------------------------------------
   // Header decode helpers
   // ---------------------------------------------------------------------
   always_comb begin
      unique case (phase_ff)
         PH_EXT16: sect_last = (cnt_ff >= EXT16_LAST);
         PH_EXT64: sect_last = (cnt_ff >= EXT64_LAST);
         PH_MASK:  sect_last = (cnt_ff >= MASK_LAST);
         default:  sect_last = 1'b0;
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         PH_HDR1: hdr_done = (len_code != LEN_CODE_16) && (len_code != LEN_CODE_64)
                             && ((rx & MASKED_FLAG) == 8'h00);
         PH_EXT16, PH_EXT64: hdr_done = sect_last && !masked_ff;
         PH_MASK: hdr_done = sect_last;
         default: hdr_done = 1'b0;
      endcase
   end

   // length check runs on the length as it stands after this beat
   assign oversize = wide_in
                   || (CMP_BITS'(len_in) > CMP_BITS'(max_len_ff));
   assign len_zero = (len_in == '0);
   assign pay_last = (rem_ff == LENGTH_BITS'(1));

   always_comb begin
      unique case (midx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
      endcase
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: phase_in = PH_HDR1;
            PH_HDR1, PH_EXT16, PH_EXT64, PH_MASK: begin
               priority if (hdr_done) begin
                  priority if (oversize) phase_in = PH_HALT;
                  else if (len_zero)     phase_in = PH_HDR0;
                  else                   phase_in = PH_PAYLOAD;
               end else if (phase_ff == PH_HDR1) begin
                  priority if (len_code == LEN_CODE_16) phase_in = PH_EXT16;
                  else if (len_code == LEN_CODE_64)     phase_in = PH_EXT64;
                  else                                  phase_in = PH_MASK;
               end else if (sect_last) begin
                  phase_in = PH_MASK;   // end of ext length, masked frame
               end else begin
                  phase_in = phase_ff;
               end
            end
            PH_PAYLOAD: phase_in = pay_last ? PH_HDR0 : PH_PAYLOAD;
            PH_HALT:    phase_in = PH_HALT;
            default:    phase_in = PH_HALT;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Datapath and result
   // ---------------------------------------------------------------------
   always_comb begin
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      len_in    = len_ff;
      wide_in   = wide_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      key_in    = key_ff;
      midx_in   = midx_ff;
      res       = '{kind: KIND_DATA, data: 8'h00, opcode: opcode_ff, fin: fin_ff,
                    last: 1'b1};
      res_vld   = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in    = ((rx & FIN_MASK) != 8'h00);
               opcode_in = 4'(rx & OPCODE_MASK);
            end
            PH_HDR1: begin
               masked_in = ((rx & MASKED_FLAG) != 8'h00);
               key_in    = '0;
               midx_in   = '0;
               cnt_in    = '0;
               wide_in   = 1'b0;
               len_in    = ((len_code == LEN_CODE_16) || (len_code == LEN_CODE_64))
                           ? '0 : LENGTH_BITS'(len_code);
            end
            PH_EXT16, PH_EXT64: begin
               len_in  = {len_ff[LENGTH_BITS-9:0], rx};
               wide_in = wide_ff || (|len_ff[LENGTH_BITS-1 -: 8]);
               cnt_in  = sect_last ? 3'd0 : cnt_ff + 3'd1;
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx};
               cnt_in = sect_last ? cnt_ff : cnt_ff + 3'd1;
            end
            PH_PAYLOAD: begin
               midx_in = midx_ff + 2'd1;
               rem_in  = rem_ff - LENGTH_BITS'(1);
               res.kind = KIND_DATA;
               res.data = rx ^ key_byte;
               res.last = pay_last;
               res_vld  = 1'b1;
            end
            PH_HALT: begin
            end
            default: begin
            end
         endcase

         if (hdr_done) begin
            priority if (oversize) begin
               res.kind = KIND_ERROR;
               res_vld  = 1'b1;
            end else if (len_zero) begin
               res.kind = KIND_EMPTY;
               res_vld  = 1'b1;
            end else begin
               rem_in  = len_in;
               midx_in = '0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register and skid slot
   // ---------------------------------------------------------------------
   assign out_take = out_vld_ff && rsp_tready;

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_take || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_in     = res;
            skid_vld_in = res_vld;
         end else begin
            out_in      = res;
            out_vld_in  = res_vld;
         end
      end else if (res_vld) begin
         skid_in     = res;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         max_len_ff  <= MAX_LEN_RESET;
         cnt_ff      <= '0;
         midx_ff     <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         midx_ff     <= midx_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
      end
   end

   // payload state needs no reset: each field is loaded before it is read
   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      fin_ff    <= fin_in;
      masked_ff <= masked_in;
      len_ff    <= len_in;
      wide_ff   <= wide_in;
      rem_ff    <= rem_in;
      key_ff    <= key_in;
      out_ff    <= out_in;
      skid_ff   <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, out_ff.fin, out_ff.opcode, out_ff.data};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `WSFD_ASSERT_NOW(a_skid_behind_out, skid_vld_ff, out_vld_ff)
   `WSFD_ASSERT_NEXT(a_halt_sticks, phase_ff == PH_HALT, phase_ff == PH_HALT)
   `WSFD_ASSERT_NOW(a_payload_nonzero, phase_ff == PH_PAYLOAD, rem_ff != '0)
   `WSFD_ASSERT_NOW(a_nondata_ends_frame, out_vld_ff && (out_ff.kind != KIND_DATA),
                    out_ff.last && (out_ff.data == 8'h00))

endmodule

### test/websocket_frame_deframer_core_tb.sv
// Self-checking testbench for the byte-serial websocket frame deframer core.
module websocket_frame_deframer_core_tb;
   import wsfd_pkg::*;

   // Ways the frame length can be coded in the header.
   localparam int FORM_SHORT = 0;   // 7-bit length in the second header byte
   localparam int FORM_EXT16 = 1;   // length code 126 + 16-bit big-endian length
   localparam int FORM_EXT64 = 2;   // length code 127 + 64-bit big-endian length

   localparam int FILL_RANDOM = -1;     // payload bytes drawn at random
   localparam int SETTLE_CYCLES = 4;    // drains output regs, covers header-only bytes
   localparam int CYCLE_LIMIT = 400000; // ~1800 beats with long gaps and stalls

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [31:0] csr_wdata;

   websocket_frame_deframer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Parser mirror: tracks the header/payload state the DUT should be in and
   // queues the result beat each accepted byte should produce.
   // ---------------------------------------------------------------------
   phase_type   hdr_phase;
   logic [3:0]  cur_opcode;
   logic        cur_fin;
   logic        cur_masked;
   logic [63:0] cur_length;
   logic [63:0] bytes_left;
   logic [2:0]  hdr_count;
   logic [31:0] cur_key;
   logic [1:0]  key_pos;
   logic [31:0] length_limit;

   beat_type    expected_beats[$];

   int          bytes_sent;
   int          mismatches;
   int          cycle_count;
   int          stall_left;
   logic        steady;      // when set, neither side inserts gaps

   // Header fully read: oversize check, then empty frame or payload.
   task automatic header_complete(output logic hit, output beat_type r);
      logic too_wide;
      too_wide = (LENGTH_BITS < 64) && ((cur_length >> LENGTH_BITS) != 0);
      hit = 1'b1;
      r = '0;
      r.opcode = cur_opcode;
      r.fin = cur_fin;
      r.last = 1'b1;
      if (too_wide || cur_length > {32'd0, length_limit}) begin
         hdr_phase = PH_HALT;
         r.kind = KIND_ERROR;
      end else if (cur_length == 0) begin
         hdr_phase = PH_HDR0;
         r.kind = KIND_EMPTY;
      end else begin
         hit = 1'b0;
         bytes_left = cur_length;
         key_pos = '0;
         hdr_phase = PH_PAYLOAD;
      end
   endtask

   // Length known: mask key next if the frame is masked.
   task automatic length_complete(output logic hit, output beat_type r);
      hdr_count = '0;
      hit = 1'b0;
      r = '0;
      if (cur_masked)
         hdr_phase = PH_MASK;
      else
         header_complete(hit, r);
   endtask

   task automatic parse_byte(input logic [7:0] b);
      beat_type    r;
      logic        hit;
      logic [7:0]  k;
      logic [2:0]  last_count;
      hit = 1'b0;
      r = '0;
      case (hdr_phase)
         PH_HDR0: begin
            cur_fin = |(b & FIN_MASK);
            cur_opcode = b[3:0] & OPCODE_MASK[3:0];
            hdr_phase = PH_HDR1;
         end
         PH_HDR1: begin
            cur_masked = |(b & MASKED_FLAG);
            cur_key = '0;
            key_pos = '0;
            hdr_count = '0;
            cur_length = {57'd0, b[6:0] & LEN_MASK[6:0]};
            if (b[6:0] == LEN_CODE_16) begin
               cur_length = '0;
               hdr_phase = PH_EXT16;
            end else if (b[6:0] == LEN_CODE_64) begin
               cur_length = '0;
               hdr_phase = PH_EXT64;
            end else begin
               length_complete(hit, r);
            end
         end
         PH_EXT16, PH_EXT64: begin
            cur_length = {cur_length[55:0], b};
            last_count = (hdr_phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;
            if (hdr_count >= last_count)
               length_complete(hit, r);
            else
               hdr_count = hdr_count + 3'd1;
         end
         PH_MASK: begin
            cur_key = {cur_key[23:0], b};
            if (hdr_count >= MASK_LAST)
               header_complete(hit, r);
            else
               hdr_count = hdr_count + 3'd1;
         end
         PH_PAYLOAD: begin
            // first key byte sits in the top bits
            k = cur_key[8 * (3 - key_pos) +: 8];
            key_pos = key_pos + 2'd1;
            bytes_left = bytes_left - 64'd1;
            hit = 1'b1;
            r.kind = KIND_DATA;
            r.data = b ^ k;
            r.opcode = cur_opcode;
            r.fin = cur_fin;
            r.last = (bytes_left == 0);
            if (r.last)
               hdr_phase = PH_HDR0;
         end
         default: ;   // halted: byte dropped
      endcase
      if (hit)
         expected_beats.insert(expected_beats.size(), r);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus plumbing
   // ---------------------------------------------------------------------

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Called at a rising edge; returns at the edge where the beat was taken.
   // valid is only lowered when a gap follows, so it never toggles in one step.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      parse_byte(b);
      bytes_sent++;
   endtask

   // Quiesce: no input in flight, every queued result seen, pipeline settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [31:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      length_limit = value;
      csr_we <= 1'b0;
   endtask

   task automatic send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input logic [31:0] key,
                              input logic [63:0] len, input int form);
      send_byte({fin, rsv, op});
      case (form)
         FORM_EXT16: begin
            send_byte({masked, LEN_CODE_16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         FORM_EXT64: begin
            send_byte({masked, LEN_CODE_64});
            for (int i = 7; i >= 0; i--)
               send_byte(len[8 * i +: 8]);
         end
         default: send_byte({masked, len[6:0]});
      endcase
      if (masked)
         for (int i = 3; i >= 0; i--)
            send_byte(key[8 * i +: 8]);
   endtask

   task automatic drive_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input logic [31:0] key,
                              input logic [63:0] len, input int form, input int fill);
      send_header(fin, rsv, op, masked, key, len, form);
      for (longint i = 0; i < len; i++)
         send_byte((fill == FILL_RANDOM) ? 8'($urandom) : 8'(fill));
   endtask

   // Well-formed frame with random header bits and content, length kept
   // within the current limit so the parser never halts.
   task automatic send_random_frame();
      logic [63:0] len;
      int          r;
      int          form;
      r = $urandom_range(0, 99);
      if (r < 12)
         len = 0;
      else if (r < 55)
         len = $urandom_range(1, 8);
      else if (r < 85)
         len = $urandom_range(9, 40);
      else if (r < 96)
         len = $urandom_range(100, 127);
      else
         len = $urandom_range(128, 300);
      if (len > {32'd0, length_limit})
         len = {32'd0, length_limit};
      r = $urandom_range(0, 99);
      if (len > 125)
         form = (r < 75) ? FORM_EXT16 : FORM_EXT64;
      else
         form = (r < 70) ? FORM_SHORT : (r < 85) ? FORM_EXT16 : FORM_EXT64;
      drive_frame(1'($urandom), 3'($urandom), 4'($urandom), $urandom_range(0, 9) < 7,
                  $urandom, len, form, FILL_RANDOM);
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure and in-order comparison
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat, expected none, actual tdata %0h tuser %0h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_beats.pop_front();
            check_field("result_kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("payload_byte", 16'(want.data), 16'(rsp_tdata[7:0]));
            check_field("frame_opcode", 16'(want.opcode), 16'(rsp_tdata[11:8]));
            check_field("final_fragment", 16'(want.fin), 16'(rsp_tdata[12]));
            check_field("tdata padding", 16'd0, 16'(rsp_tdata[15:13]));
            check_field("frame_end", 16'(want.last), 16'(rsp_tlast));
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Zero-length frames give a single empty-frame beat, masked or not.
   task automatic test_empty_frames();
      drive_frame(1'b1, 3'b000, 4'h0, 1'b0, 32'h0, 64'd0, FORM_SHORT, FILL_RANDOM);
      drive_frame(1'b0, 3'b111, 4'hF, 1'b1, 32'hFFFF_FFFF, 64'd0, FORM_SHORT, FILL_RANDOM);
   endtask

   // Unmasked bytes pass untouched; an all-ones key inverts every byte.
   task automatic test_short_frames();
      drive_frame(1'b1, 3'b101, 4'h8, 1'b0, 32'h0, 64'd1, FORM_SHORT, 8'hFF);
      drive_frame(1'b0, 3'b010, 4'h2, 1'b1, 32'hFFFF_FFFF, 64'd2, FORM_SHORT, 8'h00);
   endtask

   // Extended length codes, each with a non-minimal encoding.
   task automatic test_extended_lengths();
      drive_frame(1'b1, 3'b000, 4'h1, 1'b0, 32'h0, 64'd1, FORM_EXT16, FILL_RANDOM);
      drive_frame(1'b0, 3'b000, 4'hA, 1'b0, 32'h0, 64'd0, FORM_EXT64, FILL_RANDOM);
   endtask

   // Limit extremes and exact-fit frames at the boundary.
   task automatic test_limit_settings();
      set_limit(32'd0);
      drive_frame(1'b1, 3'b000, 4'h9, 1'b0, 32'h0, 64'd0, FORM_SHORT, FILL_RANDOM);
      set_limit(32'd3);
      drive_frame(1'b1, 3'b000, 4'hA, 1'b1, $urandom, 64'd3, FORM_SHORT, FILL_RANDOM);
      set_limit(32'hFFFF_FFFF);
      drive_frame(1'b0, 3'b000, 4'h0, 1'b0, 32'h0, 64'd2, FORM_EXT64, FILL_RANDOM);
   endtask

   // Bulk random traffic, limit reprogrammed between groups of frames.
   task automatic test_random_traffic();
      int frames;
      frames = 0;
      while (bytes_sent < 1400) begin
         if (frames % 25 == 0) begin
            case ($urandom_range(0, 4))
               0: set_limit(32'hFFFF_FFFF);
               1: set_limit(MAX_LEN_RESET);
               2: set_limit($urandom_range(0, 12));
               3: set_limit($urandom_range(13, 300));
               default: set_limit($urandom);
            endcase
         end
         send_random_frame();
         frames++;
      end
   endtask

   // Full rate on both sides: one byte per clock, no back-pressure.
   task automatic test_steady_stream();
      set_limit(32'hFFFF_FFFF);
      steady = 1'b1;
      repeat (8) send_random_frame();
      wait_idle();
      steady = 1'b0;
   endtask

   // Oversize frame: one error beat after the full header, then every byte
   // is dropped. Must run last since only reset clears the halt.
   task automatic test_oversize_halt();
      logic [31:0] lim;
      logic [63:0] len;
      case ($urandom_range(0, 2))
         0: begin
            // one past the limit
            lim = $urandom_range(0, 200);
            len = {32'd0, lim} + 64'd1;
            set_limit(lim);
            send_header(1'($urandom), 3'($urandom), 4'($urandom), 1'b1, $urandom, len,
                        (len > 125) ? FORM_EXT16 : FORM_SHORT);
         end
         1: begin
            // just past what a 32-bit limit can allow
            set_limit(32'hFFFF_FFFF);
            send_header(1'($urandom), 3'($urandom), 4'($urandom), 1'b1, $urandom,
                        64'h1_0000_0000, FORM_EXT64);
         end
         default: begin
            set_limit($urandom);
            len = {$urandom | 32'h1, 32'($urandom)};
            send_header(1'($urandom), 3'($urandom), 4'($urandom), 1'($urandom), $urandom,
                        len, FORM_EXT64);
         end
      endcase
      repeat (20) send_byte($urandom);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      steady = 1'b0;
      stall_left = 0;
      cycle_count = 0;
      bytes_sent = 0;
      mismatches = 0;

      hdr_phase = PH_HDR0;
      cur_opcode = '0;
      cur_fin = 1'b0;
      cur_masked = 1'b0;
      cur_length = '0;
      bytes_left = '0;
      hdr_count = '0;
      cur_key = '0;
      key_pos = '0;
      length_limit = MAX_LEN_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Default limit is still in force for the first tests.
      test_empty_frames();
      test_short_frames();
      test_extended_lengths();
      test_limit_settings();
      test_random_traffic();
      test_steady_stream();
      test_oversize_halt();

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/wsfd_pkg.sv
src/websocket_frame_deframer_core.sv
test/websocket_frame_deframer_core_tb.sv
